[hw/rtl/jse_pkg.sv]
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, slot layout and character helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

  localparam int SLOTS = 16;

  typedef logic [6:0]       char_t;
  typedef logic [SLOTS-1:0] slot_mask_t;
  typedef logic [3:0]       slot_t;

  // one queued item: which output slots are live plus the data they need
  typedef struct packed {
    slot_mask_t  mask;
    char_t       pre0;
    char_t       pre1;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } jse_job_t;

  // slot layout of one item's output run
  localparam slot_t SLOT_OPEN  = 4'd0;
  localparam slot_t SLOT_PRE0  = 4'd1;
  localparam slot_t SLOT_PRE1  = 4'd2;
  localparam slot_t SLOT_U0    = 4'd3;
  localparam slot_t SLOT_U1    = 4'd9;
  localparam slot_t SLOT_CLOSE = 4'd15;
  localparam int    UNIT_LEN   = 6;

  // position inside one \uXXXX group
  localparam slot_t REL_ESC = 4'd0;
  localparam slot_t REL_U   = 4'd1;
  localparam slot_t REL_D3  = 4'd2;
  localparam slot_t REL_D2  = 4'd3;
  localparam slot_t REL_D1  = 4'd4;

  localparam char_t CH_QUOTE  = 7'h22;
  localparam char_t CH_BSLASH = 7'h5C;
  localparam char_t CH_QMARK  = 7'h3F;
  localparam char_t CH_U      = 7'h75;

  function automatic char_t hex_char(input logic [3:0] d);
    char_t c;
    if (d < 4'd10) begin
      c = char_t'(7'h30 + {3'd0, d});
    end else begin
      c = char_t'(7'h37 + {3'd0, d});
    end
    return c;
  endfunction

  function automatic char_t slot_char(input jse_job_t job, input slot_t slot);
    char_t       c;
    slot_t       rel;
    logic [15:0] unit;
    c    = CH_QUOTE;
    rel  = (slot >= SLOT_U1) ? slot_t'(slot - SLOT_U1) : slot_t'(slot - SLOT_U0);
    unit = (slot >= SLOT_U1) ? job.unit1 : job.unit0;
    case (slot)
      SLOT_OPEN, SLOT_CLOSE: c = CH_QUOTE;
      SLOT_PRE0:             c = job.pre0;
      SLOT_PRE1:             c = job.pre1;
      default: begin
        case (rel)
          REL_ESC: c = CH_BSLASH;
          REL_U:   c = CH_U;
          REL_D3:  c = hex_char(unit[15:12]);
          REL_D2:  c = hex_char(unit[11:8]);
          REL_D1:  c = hex_char(unit[7:4]);
          default: c = hex_char(unit[3:0]);
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/jse_front.sv]
// ----------------------------------------------------------------------------
// jse_front
// Classifies each string byte, tracks the UTF-8 sequence state and builds
// the slot descriptor of the characters the byte produces.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_front import jse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     take,
  input  wire logic [7:0] in_byte,
  input  wire logic     in_eos,
  output logic          job_push,
  output jse_job_t      job
);

  localparam logic [7:0] B_QUOTE  = 8'h22;
  localparam logic [7:0] B_BSLASH = 8'h5C;
  localparam logic [7:0] B_SLASH  = 8'h2F;
  localparam logic [7:0] B_BS     = 8'h08;
  localparam logic [7:0] B_TAB    = 8'h09;
  localparam logic [7:0] B_LF     = 8'h0A;
  localparam logic [7:0] B_FF     = 8'h0C;
  localparam logic [7:0] B_CR     = 8'h0D;

  logic        at_start_r, at_start_nxt;
  logic        term_r, term_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [30:0] cp_r, cp_nxt;

  logic [2:0]  rem_after;
  logic [30:0] cp_after;
  logic        term_after;
  logic        code_go;
  logic        close;
  logic [1:0]  nb;
  char_t       c0, c1;
  logic        code_one, code_pair, code_q;
  logic [4:0]  plane;
  logic [1:0]  npre;
  jse_job_t    job_c;

  always_comb begin
    rem_after  = rem_r;
    cp_after   = cp_r;
    term_after = term_r;
    code_go    = 1'b0;
    close      = 1'b0;
    nb         = 2'd0;
    c0         = CH_QMARK;
    c1         = CH_QMARK;
    if (in_byte == 8'h00) begin
      code_go    = (rem_r != 3'd0);
      close      = 1'b1;
      term_after = 1'b1;
      rem_after  = 3'd0;
    end else if (rem_r != 3'd0) begin
      if (in_byte[7:6] == 2'b10) begin
        cp_after = {cp_r[24:0], in_byte[5:0]};
      end else begin
        nb = 2'd1;
        c0 = CH_QMARK;
      end
      rem_after = 3'(rem_r - 3'd1);
      code_go   = (rem_after == 3'd0);
    end else if (in_byte == B_QUOTE || in_byte == B_BSLASH || in_byte == B_SLASH) begin
      nb = 2'd2;
      c0 = CH_BSLASH;
      c1 = in_byte[6:0];
    end else if (!in_byte[7] && in_byte[6:5] != 2'b00) begin
      nb = 2'd1;
      c0 = in_byte[6:0];
    end else if (in_byte == B_BS) begin
      nb = 2'd2; c0 = CH_BSLASH; c1 = 7'h62;
    end else if (in_byte == B_TAB) begin
      nb = 2'd2; c0 = CH_BSLASH; c1 = 7'h74;
    end else if (in_byte == B_LF) begin
      nb = 2'd2; c0 = CH_BSLASH; c1 = 7'h6E;
    end else if (in_byte == B_FF) begin
      nb = 2'd2; c0 = CH_BSLASH; c1 = 7'h66;
    end else if (in_byte == B_CR) begin
      nb = 2'd2; c0 = CH_BSLASH; c1 = 7'h72;
    end else if (in_byte[7:5] == 3'b110) begin
      cp_after = {26'd0, in_byte[4:0]}; rem_after = 3'd1;
    end else if (in_byte[7:4] == 4'b1110) begin
      cp_after = {27'd0, in_byte[3:0]}; rem_after = 3'd2;
    end else if (in_byte[7:3] == 5'b11110) begin
      cp_after = {28'd0, in_byte[2:0]}; rem_after = 3'd3;
    end else if (in_byte[7:2] == 6'b111110) begin
      cp_after = {29'd0, in_byte[1:0]}; rem_after = 3'd4;
    end else if (in_byte[7:1] == 7'b1111110) begin
      cp_after = {30'd0, in_byte[0]}; rem_after = 3'd5;
    end else begin
      nb = 2'd1;
      c0 = CH_QMARK;
    end
    // end of string closes any open sequence with the bits so far
    if (in_eos && in_byte != 8'h00) begin
      if (rem_after != 3'd0) begin
        code_go = 1'b1;
      end
      close = 1'b1;
    end
  end

  // code point to utf-16 units
  always_comb begin
    code_one  = code_go && (cp_after[30:16] == 15'd0);
    code_pair = code_go && !code_one && (cp_after <= 31'h10FFFF);
    code_q    = code_go && !code_one && !code_pair;
    plane     = 5'(cp_after[20:16] - 5'd1);
  end

  always_comb begin
    job_c       = '0;
    job_c.unit0 = code_one ? cp_after[15:0] : {6'b110110, plane[3:0], cp_after[15:10]};
    job_c.unit1 = {6'b110111, cp_after[9:0]};
    job_c.pre0  = c0;
    job_c.pre1  = c1;
    npre        = nb;
    if (code_q) begin
      if (nb == 2'd0) begin
        job_c.pre0 = CH_QMARK;
      end else begin
        job_c.pre1 = CH_QMARK;
      end
      npre = 2'(nb + 2'd1);
    end
    job_c.mask[SLOT_OPEN]  = at_start_r;
    job_c.mask[SLOT_PRE0]  = (npre != 2'd0);
    job_c.mask[SLOT_PRE1]  = (npre == 2'd2);
    for (int i = 0; i < UNIT_LEN; i++) begin
      job_c.mask[int'(SLOT_U0) + i] = code_one || code_pair;
      job_c.mask[int'(SLOT_U1) + i] = code_pair;
    end
    job_c.mask[SLOT_CLOSE] = close;
    if (term_r) begin
      job_c.mask = '0;
    end
  end

  assign job      = job_c;
  assign job_push = take && (job_c.mask != '0);

  always_comb begin
    at_start_nxt = at_start_r;
    term_nxt     = term_r;
    rem_nxt      = rem_r;
    cp_nxt       = cp_r;
    if (take) begin
      if (in_eos) begin
        at_start_nxt = 1'b1;
        term_nxt     = 1'b0;
        rem_nxt      = 3'd0;
        cp_nxt       = '0;
      end else if (!term_r) begin
        at_start_nxt = 1'b0;
        term_nxt     = term_after;
        rem_nxt      = code_go ? 3'd0 : rem_after;
        cp_nxt       = code_go ? 31'd0 : cp_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      term_r     <= 1'b0;
      rem_r      <= 3'd0;
      cp_r       <= '0;
    end else begin
      at_start_r <= at_start_nxt;
      term_r     <= term_nxt;
      rem_r      <= rem_nxt;
      cp_r       <= cp_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/jse_queue.sv]
// ----------------------------------------------------------------------------
// jse_queue
// Small register queue of item descriptors between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_queue import jse_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire jse_job_t wdata,
  output logic          full,
  input  wire logic     pop,
  output jse_job_t      rdata,
  output logic          empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  jse_job_t      slots_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slots_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == LAST) ? '0 : PW'(wr_r + 1'b1);
    end
    if (pop) begin
      rd_nxt = (rd_r == LAST) ? '0 : PW'(rd_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/jse_back.sv]
// ----------------------------------------------------------------------------
// jse_back
// Walks the live slots of one descriptor at a time and emits one character
// per cycle into the output register while that register is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_back import jse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_empty,
  input  wire jse_job_t q_data,
  output logic          q_pop,
  input  wire logic     out_pop,
  output logic          out_empty,
  output char_t         out_char,
  output logic          out_last
);

  jse_job_t   job_r, job_nxt;
  slot_mask_t mask_r, mask_nxt;
  logic       out_valid_r, out_valid_nxt;
  char_t      out_char_r;
  logic       out_last_r;

  slot_mask_t lowest, rem_mask;
  slot_t      slot;
  logic       adv, emit, last;

  always_comb begin
    lowest = mask_r & slot_mask_t'(~mask_r + 1'b1);
    slot   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (lowest[i]) begin
        slot = slot_t'(i);
      end
    end
    rem_mask = mask_r & ~lowest;
    last     = (rem_mask == '0);
    adv      = !out_valid_r || out_pop;
    emit     = adv && (mask_r != '0);
    // refill when idle, or when the last slot of this item leaves now
    q_pop    = !q_empty && ((mask_r == '0) || (emit && last));
  end

  always_comb begin
    job_nxt       = job_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      mask_nxt = rem_mask;
    end
    if (q_pop) begin
      job_nxt  = q_data;
      mask_nxt = q_data.mask;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (emit) begin
      out_char_r <= slot_char(job_r, slot);
      out_last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  a_load_live: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_data.mask != '0))
    else $error("queued descriptor with no live slot");

  a_idle_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (mask_r == '0) && !q_empty |-> q_pop)
    else $error("back idle while descriptors wait");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted character not presented");

  a_mid_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !last |=> (mask_r != '0))
    else $error("item run dropped before its last character");

endmodule

`default_nettype wire

[hw/rtl/json_string_escaper.sv]
// an item goes through the queue, the back-end descriptor register and the output register
// throughput: one output character per cycle while the receiver pops, set by the
//   single character register of the back end; an item produces 0 to 14 characters
// input takes one byte per cycle while the descriptor queue (QUEUE_DEPTH entries) has room
// reset: synchronous, active low; clears sequence state, queue and output register,
//   and leaves the opening quote pending
// ----------------------------------------------------------------------------
// json_string_escaper
// Turns string bytes into quoted, escaped JSON text with utf-16 \u escapes.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper import jse_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_string,
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      out_char,
  output logic            out_last_of_run
);

  logic     take;
  logic     job_push;
  jse_job_t job_w;
  jse_job_t q_data;
  logic     q_empty;
  logic     q_pop;

  assign take = push && !full;

  jse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_byte  (in_byte),
    .in_eos   (in_end_of_string),
    .job_push (job_push),
    .job      (job_w)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_w),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  jse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_char  (out_char),
    .out_last  (out_last_of_run)
  );

endmodule

`default_nettype wire

[verif/json_string_escaper_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_escaper_checker
// Watches both queue ports of the escaper, predicts the quoted JSON text for
// every byte transfer and compares each character transfer against it.
// ----------------------------------------------------------------------------

module json_string_escaper_checker import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  input  logic       empty,
  input  logic       pop,
  input  logic [6:0] out_char,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         chars_waiting,
  output int         chars_checked
);

  localparam logic [7:0] BYTE_NUL    = 8'h00;
  localparam logic [7:0] BYTE_QUOTE  = 8'h22;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_SLASH  = 8'h2F;
  localparam logic [7:0] BYTE_BKSP   = 8'h08;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_FF     = 8'h0C;
  localparam logic [7:0] BYTE_CR     = 8'h0D;

  localparam char_t CH_ZERO    = 7'h30;
  localparam char_t CH_UPPER_A = 7'h41;
  localparam char_t CH_LOWER_B = 7'h62;
  localparam char_t CH_LOWER_T = 7'h74;
  localparam char_t CH_LOWER_N = 7'h6E;
  localparam char_t CH_LOWER_F = 7'h66;
  localparam char_t CH_LOWER_R = 7'h72;

  localparam int MAX_RUN = 16;

  typedef struct packed {
    char_t ch;
    logic  last;
  } text_char_t;

  text_char_t  escaped_q[$];
  char_t       run_chars[$];

  // escaper state
  logic        at_open;
  logic [2:0]  cont_left;
  logic [30:0] code_acc;
  logic        nul_seen;

  function automatic char_t hex_digit(input logic [3:0] d);
    if (d < 4'd10) begin
      return char_t'(CH_ZERO + d);
    end
    return char_t'(CH_UPPER_A + (d - 4'd10));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic emit(input char_t c);
    if (run_chars.size() < MAX_RUN) begin
      run_chars.insert(run_chars.size(), c);
    end
  endtask

  task automatic emit_utf16(input logic [15:0] u);
    emit(CH_BSLASH);
    emit(CH_U);
    emit(hex_digit(u[15:12]));
    emit(hex_digit(u[11:8]));
    emit(hex_digit(u[7:4]));
    emit(hex_digit(u[3:0]));
  endtask

  task automatic flush_code_point();
    logic [31:0] offset;
    if (code_acc <= 31'h0000FFFF) begin
      emit_utf16(code_acc[15:0]);
    end else begin
      offset = {1'b0, code_acc} - 32'h00010000;
      // the high half has to fit ten bits for a surrogate pair
      if (offset[31:20] == '0) begin
        emit_utf16(16'hD800 | {6'd0, offset[19:10]});
        emit_utf16(16'hDC00 | {6'd0, offset[9:0]});
      end else begin
        emit(CH_QMARK);
      end
    end
    code_acc = '0;
  endtask

  task automatic clear_string();
    at_open   = 1'b1;
    cont_left = '0;
    code_acc  = '0;
    nul_seen  = 1'b0;
  endtask

  task automatic start_sequence(input logic [30:0] bits, input logic [2:0] more);
    code_acc  = bits;
    cont_left = more;
  endtask

  task automatic escape_byte(input logic [7:0] b, input logic eos);
    text_char_t t;
    run_chars.delete();
    if (!nul_seen) begin
      if (at_open) begin
        emit(CH_QUOTE);
        at_open = 1'b0;
      end
      if (b == BYTE_NUL) begin
        if (cont_left != 0) begin
          cont_left = '0;
          flush_code_point();
        end
        emit(CH_QUOTE);
        nul_seen = 1'b1;
      end else if (cont_left != 0) begin
        // a bad continuation still uses up one position of the sequence
        if (b[7:6] == 2'b10) begin
          code_acc = {code_acc[24:0], b[5:0]};
        end else begin
          emit(CH_QMARK);
        end
        cont_left--;
        if (cont_left == 0) begin
          flush_code_point();
        end
      end else if (b == BYTE_QUOTE || b == BYTE_BSLASH || b == BYTE_SLASH) begin
        emit(CH_BSLASH);
        emit(b[6:0]);
      end else if (b >= 8'h20 && b <= 8'h7F) begin
        emit(b[6:0]);
      end else begin
        case (b)
          BYTE_BKSP: begin emit(CH_BSLASH); emit(CH_LOWER_B); end
          BYTE_TAB:  begin emit(CH_BSLASH); emit(CH_LOWER_T); end
          BYTE_LF:   begin emit(CH_BSLASH); emit(CH_LOWER_N); end
          BYTE_FF:   begin emit(CH_BSLASH); emit(CH_LOWER_F); end
          BYTE_CR:   begin emit(CH_BSLASH); emit(CH_LOWER_R); end
          default: begin
            if (b[7:5] == 3'b110) begin
              start_sequence({26'd0, b[4:0]}, 3'd1);
            end else if (b[7:4] == 4'b1110) begin
              start_sequence({27'd0, b[3:0]}, 3'd2);
            end else if (b[7:3] == 5'b11110) begin
              start_sequence({28'd0, b[2:0]}, 3'd3);
            end else if (b[7:2] == 6'b111110) begin
              start_sequence({29'd0, b[1:0]}, 3'd4);
            end else if (b[7:1] == 7'b1111110) begin
              start_sequence({30'd0, b[0]}, 3'd5);
            end else begin
              emit(CH_QMARK);
            end
          end
        endcase
      end
      if (eos && !nul_seen) begin
        if (cont_left != 0) begin
          cont_left = '0;
          flush_code_point();
        end
        emit(CH_QUOTE);
      end
    end
    if (eos) begin
      clear_string();
    end
    foreach (run_chars[i]) begin
      t.ch   = run_chars[i];
      t.last = (i == run_chars.size() - 1);
      escaped_q.insert(escaped_q.size(), t);
    end
  endtask

  task automatic check_char();
    text_char_t want;
    if (escaped_q.size() == 0) begin
      report_mismatch("character with none expected", out_char, 0);
    end else begin
      want = escaped_q.pop_front();
      if (out_char !== want.ch) begin
        report_mismatch("out_char", out_char, want.ch);
      end
      if (out_last_of_run !== want.last) begin
        report_mismatch("out_last_of_run", out_last_of_run, want.last);
      end
    end
    chars_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_string();
      escaped_q.delete();
      chars_waiting <= 0;
    end else begin
      if (push && !full) begin
        escape_byte(in_byte, in_end_of_string);
      end
      if (pop && !empty) begin
        check_char();
      end
      chars_waiting <= escaped_q.size();
    end
  end

endmodule

[verif/json_string_escaper_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_escaper_tb
// Feeds directed and random UTF-8 strings into the escaper with random gaps
// and output stalls; a checker beside the block predicts the escaped text.
// ----------------------------------------------------------------------------

module json_string_escaper_tb;

  localparam int RESET_CYCLES  = 7;
  localparam int TOTAL_ITEMS   = 325;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_STRING   = 6;
  localparam int PAUSE_STRING  = 14;
  localparam int QUIET_FIRST   = 20;
  localparam int QUIET_LAST    = 27;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       push             = 1'b0;
  logic       full;
  logic [7:0] in_byte          = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       empty;
  logic       pop              = 1'b0;
  logic [6:0] out_char;
  logic       out_last_of_run;

  int fail_count;
  int chars_waiting;
  int chars_checked;

  int items_sent   = 0;
  int strings_sent = 0;
  int cycle_count  = 0;
  int hold_left    = 0;
  bit no_idle      = 1'b0;
  bit hold_req     = 1'b0;

  logic [7:0] str_bytes[$];

  json_string_escaper i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .empty            (empty),
    .pop              (pop),
    .out_char         (out_char),
    .out_last_of_run  (out_last_of_run)
  );

  json_string_escaper_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .empty            (empty),
    .pop              (pop),
    .out_char         (out_char),
    .out_last_of_run  (out_last_of_run),
    .fail_count       (fail_count),
    .chars_waiting    (chars_waiting),
    .chars_checked    (chars_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_count, chars_waiting);
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random pop, plus one long hold-off counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(99) >= 25);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eos);
    while (!no_idle && $urandom_range(99) < 25) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push             <= 1'b1;
    in_byte          <= b;
    in_end_of_string <= eos;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // stop offering bytes until every predicted character has been popped
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (chars_waiting != 0) @(posedge clk);
  endtask

  task automatic add_sequence(input bit broken);
    int         len;
    int         bad_pos;
    logic [7:0] ones;
    logic [7:0] lead;
    logic [7:0] tail[$];
    ones = 8'hFF;
    len  = $urandom_range(2, 6);
    lead = (ones << (8 - len)) | (8'($urandom) & (ones >> (len + 1)));
    str_bytes.insert(str_bytes.size(), lead);
    for (int i = 1; i < len; i++) begin
      tail.insert(tail.size(), 8'h80 | 8'($urandom_range(0, 63)));
    end
    if (broken) begin
      bad_pos = $urandom_range(0, len - 2);
      if ($urandom_range(1) == 0) begin
        // cut the sequence short
        while (tail.size() > bad_pos) tail.delete(tail.size() - 1);
      end else if ($urandom_range(1) == 0) begin
        tail[bad_pos] = 8'($urandom_range(1, 127));
      end else begin
        tail[bad_pos] = 8'($urandom_range(192, 255));
      end
    end
    foreach (tail[i]) str_bytes.insert(str_bytes.size(), tail[i]);
  endtask

  task automatic build_string();
    int n_tok;
    int pick;
    str_bytes.delete();
    n_tok = $urandom_range(1, 8);
    repeat (n_tok) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        add_sequence(1'b0);
      end else if (pick < 62) begin
        add_sequence(1'b1);
      end else if (pick < 80) begin
        str_bytes.insert(str_bytes.size(), 8'($urandom_range(32, 127)));
      end else if (pick < 90) begin
        case ($urandom_range(7))
          0:       str_bytes.insert(str_bytes.size(), 8'h22);
          1:       str_bytes.insert(str_bytes.size(), 8'h5C);
          2:       str_bytes.insert(str_bytes.size(), 8'h2F);
          3:       str_bytes.insert(str_bytes.size(), 8'h08);
          4:       str_bytes.insert(str_bytes.size(), 8'h09);
          5:       str_bytes.insert(str_bytes.size(), 8'h0A);
          6:       str_bytes.insert(str_bytes.size(), 8'h0C);
          default: str_bytes.insert(str_bytes.size(), 8'h0D);
        endcase
      end else begin
        str_bytes.insert(str_bytes.size(), 8'($urandom_range(1, 255)));
      end
    end
    // now and then an early zero byte
    if ($urandom_range(99) < 6) begin
      str_bytes.insert($urandom_range(0, str_bytes.size() - 1), 8'h00);
    end
  endtask

  task automatic send_string();
    foreach (str_bytes[i]) send_item(str_bytes[i], i == str_bytes.size() - 1);
    strings_sent++;
  endtask

  initial begin
    logic [8:0] directed[$];
    // bit 8 marks the end of a string
    directed = '{9'h020, 9'h022, 9'h05C, 9'h02F, 9'h008, 9'h009, 9'h00A, 9'h00C,
                 9'h00D, 9'h001, 9'h080, 9'h0FE, 9'h0FF, 9'h17F,
                 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
                 9'h0E2, 9'h041, 9'h082,
                 9'h0C3, 9'h000, 9'h055, 9'h1FD};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_item(directed[i][7:0], directed[i][8]);

    while (items_sent < TOTAL_ITEMS) begin
      no_idle = (strings_sent >= QUIET_FIRST && strings_sent <= QUIET_LAST);
      if (strings_sent == HOLD_STRING) begin
        hold_req = 1'b1;
      end
      build_string();
      send_string();
      if (strings_sent == PAUSE_STRING) begin
        drain_results();
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d byte transfers (%0d random strings), %0d characters checked",
             items_sent, strings_sent, chars_checked);
    $display("mix: all escapes, 2 to 6 byte UTF-8, surrogates, broken and cut sequences");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
